// ===== rtl/bfha_pkg.sv =====
package bfha_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  localparam logic [16:0] HEAP_MIN = 17'd64;
  localparam logic [16:0] HEAP_MAX = 17'd65536;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_NULL    = 2'd3;

  typedef struct packed {
    logic        used;
    logic [16:0] size;
    logic [15:0] start;
  } seg_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_SHR,
    S_SHW,
    S_WNEW,
    S_WSEG,
    S_DONE
  } state_t;

endpackage

// ===== rtl/bfha_ram.sv =====
module bfha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/best_fit_heap_allocator.sv =====
// Best-fit heap allocator. The segment table lives in one 64-entry RAM with
// registered read. Each request scans the table at one entry per cycle,
// then a split or merge moves the entries above the touched one, each read
// and then written back, and writes the changed entries. A null free skips
// the scan. Items are taken one at a time; a result waits in the output
// register while the next item is accepted. After reset or a heap_bytes write
// the block sets up entry 0 in S_INIT before it takes an item.
module best_fit_heap_allocator
  import bfha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // request_bytes[15:0], free_address[31:16]
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_address[15:0]
  output logic [1:0]  out_tuser   // status[1:0]
);

  state_t state_r, state_nxt;

  logic [16:0]      heap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r, pidx_r, fidx_r, k_r, j_r;
  logic             pv_r, found_r, nxt_ok_r, up_r, func_r;
  logic [16:0]      total_r, bdiff_r;
  logic [15:0]      addr_r;
  logic [1:0]       r_r;
  seg_t             fseg_r, prev_r, last_r, nseg_r, mseg_r;
  logic [1:0]       res_status_r;
  logic [15:0]      res_addr_r;
  logic             out_valid_r;
  logic [15:0]      out_addr_r;
  logic [1:0]       out_status_r;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  seg_t             wdata, rd;
  logic [$bits(seg_t)-1:0] rd_bits;

  logic             accept, split, more, left_m, right_m, cand, hit;
  logic [16:0]      diff, tot_c;
  logic [CNT_W-1:0] jr_sum;

  assign rd        = seg_t'(rd_bits);
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  assign tot_c  = ({1'b0, in_tdata[15:0]} + 17'(HEADER_BYTES) + 17'd15) & ~17'd15;
  assign diff   = rd.size - total_r;
  assign cand   = !rd.used && (rd.size >= total_r);
  assign hit    = ({1'b0, rd.start} + 17'(HEADER_BYTES)) == {1'b0, addr_r};
  assign split  = (bdiff_r > 17'(2 * HEADER_BYTES)) && (count_r < CNT_W'(MAX_SEGMENTS));
  assign left_m  = (fidx_r != '0) && !prev_r.used;
  assign right_m = nxt_ok_r && !nseg_r.used;
  assign jr_sum = j_r + CNT_W'(r_r);
  assign more   = up_r ? (j_r > fidx_r + CNT_W'(1))
                       : ((r_r != 2'd0) && (jr_sum < count_r));

  bfha_ram #(
    .WIDTH($bits(seg_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_bits)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == FUNC_FREE && in_tdata[31:16] == 16'd0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: if (idx_r == count_r && !pv_r) state_nxt = S_EVAL;
      S_EVAL: begin
        if (!found_r) begin
          state_nxt = S_DONE;
        end else if (func_r == FUNC_ALLOC && split) begin
          state_nxt = S_SHR;
        end else begin
          state_nxt = S_WSEG;
        end
      end
      S_SHR:  state_nxt = more ? S_SHW : (up_r ? S_WNEW : S_DONE);
      S_SHW:  state_nxt = S_SHR;
      S_WNEW: state_nxt = S_WSEG;
      S_WSEG: state_nxt = up_r ? S_DONE : S_SHR;
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
    if (cfg_wr_en) state_nxt = S_INIT;
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = mseg_r;
    raddr = idx_r[IDX_W-1:0];
    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = '{used: 1'b0, size: heap_r, start: 16'd0};
      end
      S_SHR: raddr = up_r ? IDX_W'(j_r - CNT_W'(1)) : jr_sum[IDX_W-1:0];
      S_SHW: begin
        we    = 1'b1;
        waddr = j_r[IDX_W-1:0];
        wdata = rd;
      end
      S_WNEW: begin
        we    = 1'b1;
        waddr = IDX_W'(fidx_r + CNT_W'(1));
        wdata = nseg_r;
      end
      S_WSEG: begin
        we    = 1'b1;
        waddr = k_r[IDX_W-1:0];
        wdata = mseg_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      heap_r      <= HEAP_MAX;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        if (cfg_wr_data < HEAP_MIN) heap_r <= HEAP_MIN;
        else if (cfg_wr_data > HEAP_MAX) heap_r <= HEAP_MAX;
        else heap_r <= cfg_wr_data;
      end
      case (state_r)
        S_INIT: count_r <= CNT_W'(1);
        S_SHR: if (!more && !up_r) count_r <= count_r - CNT_W'(r_r);
        S_WNEW: count_r <= count_r + CNT_W'(1);
        default: ;
      endcase
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= res_addr_r;
        out_status_r <= res_status_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        func_r     <= in_tuser;
        total_r    <= tot_c;
        addr_r     <= in_tdata[31:16];
        idx_r      <= '0;
        pv_r       <= 1'b0;
        found_r    <= 1'b0;
        nxt_ok_r   <= 1'b0;
        res_addr_r <= 16'd0;
        res_status_r <= ST_NULL;
      end
      S_SCAN: begin
        if (idx_r < count_r) begin
          idx_r  <= idx_r + CNT_W'(1);
          pv_r   <= 1'b1;
          pidx_r <= idx_r;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) begin
          last_r <= rd;
          if (func_r == FUNC_ALLOC) begin
            if (cand && (!found_r || diff < bdiff_r)) begin
              found_r <= 1'b1;
              fidx_r  <= pidx_r;
              fseg_r  <= rd;
              bdiff_r <= diff;
            end
          end else if (!found_r && hit) begin
            found_r <= 1'b1;
            fidx_r  <= pidx_r;
            fseg_r  <= rd;
            prev_r  <= last_r;
          end else if (found_r && pidx_r == fidx_r + CNT_W'(1)) begin
            nxt_ok_r <= 1'b1;
            nseg_r   <= rd;
          end
        end
      end
      S_EVAL: begin
        res_addr_r <= 16'd0;
        if (!found_r) begin
          res_status_r <= (func_r == FUNC_ALLOC) ? ST_NO_FIT : ST_UNKNOWN;
        end else if (func_r == FUNC_ALLOC) begin
          res_status_r <= ST_DONE;
          res_addr_r   <= fseg_r.start + 16'(HEADER_BYTES);
          k_r  <= fidx_r;
          up_r <= 1'b1;
          j_r  <= count_r;
          nseg_r <= '{used: 1'b0, size: bdiff_r, start: fseg_r.start + total_r[15:0]};
          mseg_r <= '{used: 1'b1, size: split ? total_r : fseg_r.size,
                      start: fseg_r.start};
        end else begin
          // merge with free neighbors; at most one on each side
          res_status_r <= ST_DONE;
          up_r <= 1'b0;
          r_r  <= {1'b0, left_m} + {1'b0, right_m};
          k_r  <= left_m ? fidx_r - CNT_W'(1) : fidx_r;
          j_r  <= (left_m ? fidx_r - CNT_W'(1) : fidx_r) + CNT_W'(1);
          mseg_r <= '{used: 1'b0,
                      size: fseg_r.size + (left_m ? prev_r.size : 17'd0)
                            + (right_m ? nseg_r.size : 17'd0),
                      start: left_m ? prev_r.start : fseg_r.start};
        end
      end
      S_SHW: j_r <= up_r ? j_r - CNT_W'(1) : j_r + CNT_W'(1);
      default: ;
    endcase
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import bfha_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  typedef struct packed {
    logic        func;
    logic [15:0] req;
    logic [15:0] addr;
  } request_t;

  typedef struct packed {
    logic [15:0] payload;
    logic [1:0]  status;
  } grant_t;

  best_fit_heap_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow heap table
  logic [16:0] heap_size;
  logic [15:0] seg_start [MAX_SEGMENTS];
  logic [16:0] seg_size  [MAX_SEGMENTS];
  logic        seg_used  [MAX_SEGMENTS];
  int          seg_count;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  logic [15:0] live_addrs[$];
  int  errors;
  bit  calm;
  bit  hold_off;
  int  hold_cnt;
  bit  in_acc;
  int  in_gap;
  int  out_gap;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void reset_table(input logic [16:0] bytes);
    heap_size = bytes;
    seg_count = 1;
    seg_start[0] = '0;
    seg_size[0] = bytes;
    seg_used[0] = 1'b0;
  endfunction

  function automatic void drop_entry(input int k);
    for (int j = k; j + 1 < seg_count; j++) begin
      seg_start[j] = seg_start[j + 1];
      seg_size[j]  = seg_size[j + 1];
      seg_used[j]  = seg_used[j + 1];
    end
    seg_count--;
  endfunction

  function automatic grant_t predict_grant(input request_t r);
    grant_t g;
    int total;
    int best_slack;
    int best;
    int i;
    bit hit;
    g = '0;
    hit = 1'b0;
    if (r.func == FUNC_ALLOC) begin
      total = (int'(r.req) + HEADER_BYTES + 15) & ~15;
      best_slack = 32'h7fffffff;
      best = 0;
      for (i = 0; i < seg_count; i++) begin
        if (!seg_used[i] && int'(seg_size[i]) >= total &&
            int'(seg_size[i]) - total < best_slack) begin
          best_slack = int'(seg_size[i]) - total;
          best = i;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        g.status = ST_NO_FIT;
        return g;
      end
      if (best_slack > 2 * HEADER_BYTES && seg_count < MAX_SEGMENTS) begin
        for (i = seg_count; i > best + 1; i--) begin
          seg_start[i] = seg_start[i - 1];
          seg_size[i]  = seg_size[i - 1];
          seg_used[i]  = seg_used[i - 1];
        end
        seg_start[best + 1] = 16'(int'(seg_start[best]) + total);
        seg_size[best + 1]  = 17'(best_slack);
        seg_used[best + 1]  = 1'b0;
        seg_count++;
        seg_size[best] = 17'(total);
      end
      seg_used[best] = 1'b1;
      g.payload = 16'(int'(seg_start[best]) + HEADER_BYTES);
      g.status = ST_DONE;
      return g;
    end
    if (r.addr == 0) begin
      g.status = ST_NULL;
      return g;
    end
    for (i = 0; i < seg_count; i++) begin
      if (int'(seg_start[i]) + HEADER_BYTES == int'(r.addr)) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      g.status = ST_UNKNOWN;
      return g;
    end
    seg_used[i] = 1'b0;
    while (i > 0 && !seg_used[i - 1]) begin
      seg_size[i - 1] += seg_size[i];
      drop_entry(i);
      i--;
    end
    while (i + 1 < seg_count && !seg_used[i + 1]) begin
      seg_size[i] += seg_size[i + 1];
      drop_entry(i + 1);
    end
    g.status = ST_DONE;
    return g;
  endfunction

  // Driver: present beats from the pending queue, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_acc) begin
        void'(pending_reqs.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!calm && !(in_tvalid && !in_acc) && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_reqs[0].func;
        in_tdata  <= {pending_reqs[0].addr, pending_reqs[0].req};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on acceptance
  always @(posedge clk) begin
    grant_t g;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      g = predict_grant(request_t'({in_tuser, in_tdata[15:0], in_tdata[31:16]}));
      expected_grants.push_back(g);
      if (in_tuser == FUNC_ALLOC && g.status == ST_DONE) begin
        live_addrs.push_back(g.payload);
      end
    end
  end

  // Receiver readiness
  always @(negedge clk) begin
    if (hold_off && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected beat: payload_address %0d status %0d", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (out_tdata !== want.payload) begin
          $error("payload_address expected %0d actual %0d", want.payload, out_tdata);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic push_alloc(input logic [15:0] bytes);
    request_t r;
    r = '0;
    r.func = FUNC_ALLOC;
    r.req = bytes;
    r.addr = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic push_free(input logic [15:0] where);
    request_t r;
    r = '0;
    r.func = FUNC_FREE;
    r.addr = where;
    r.req = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_grants.size() > 0) begin
      @(posedge clk);
    end
    repeat (3 * MAX_SEGMENTS + 10) @(posedge clk);
  endtask

  task automatic write_heap(input logic [16:0] bytes);
    logic [16:0] clipped;
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= bytes;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    clipped = bytes < HEAP_MIN ? HEAP_MIN : (bytes > HEAP_MAX ? HEAP_MAX : bytes);
    reset_table(clipped);
    live_addrs.delete();
  endtask

  // Allocations, mostly of small sizes, mixed with frees of live, stray and null addresses
  task automatic random_phase(input int count, input int span);
    int k;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_alloc(16'($urandom_range(0, span)));
      end else if (pick < 47) begin
        push_alloc(16'($urandom));
      end else if (pick < 85 && live_addrs.size() > 0) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        push_free(live_addrs[k]);
        live_addrs.delete(k);
      end else if (pick < 92) begin
        push_free(16'($urandom));
      end else if (pick < 95) begin
        push_free(16'h0);
      end else begin
        push_free(16'(16 * $urandom_range(1, 64)));
      end
      // Keep the predicted live list close to what was granted
      while (pending_reqs.size() > 4) @(posedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    reset_table(HEAP_MAX);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and every status
    push_alloc(16'h0);
    push_alloc(16'hffff);
    push_alloc(16'd1);
    push_free(16'h0);
    push_free(16'hffff);
    push_free(16'd16);
    push_free(16'd16);
    push_alloc(16'd65520);
    push_alloc(16'd0);
    push_free(16'd16);
    push_alloc(16'd65504);
    push_alloc(16'd0);
    drain();
    // Zero-byte request after an allocation that takes the whole heap gets no fit
    write_heap(HEAP_MAX);
    push_alloc(16'd65504);
    push_alloc(16'd0);
    drain();
    // Fill the table to its limit so splits stop
    write_heap(HEAP_MAX);
    for (int n = 0; n < 70; n++) push_alloc(16'd1);
    drain();

    write_heap(17'd0);
    push_alloc(16'd0);
    push_alloc(16'd48);
    drain();
    write_heap(17'h1ffff);
    // Back-pressure: receiver holds off while items keep coming
    hold_off = 1'b1;
    for (int n = 0; n < 8; n++) push_alloc(16'($urandom_range(0, 200)));
    wait (hold_cnt == HOLD_CYCLES);
    random_phase(250, 900);
    drain();
    write_heap(17'd1024);
    random_phase(200, 120);
    drain();
    write_heap(17'd64);
    random_phase(60, 40);
    drain();
    write_heap(17'd4096);
    random_phase(200, 300);
    drain();
    calm = 1'b1;
    random_phase(150, 2000);
    drain();

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
